// ===== src/msq_pkg.sv =====
// ---------------------------------------------------------------------------
// msq_pkg
// Shared constants and types of the magic square checker.
// ---------------------------------------------------------------------------
package msq_pkg;

	localparam int MAX_SIZE  = 16;
	localparam int IDX_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SIDE_W    = $clog2(MAX_SIZE + 1);
	localparam int SIZE_W    = 5;
	localparam int CMP_W     = (SIZE_W > SIDE_W) ? SIZE_W : SIDE_W;
	localparam int ELEM_W    = 16;
	localparam int SUM_W     = 21;
	localparam int OUT_SUM_W = 20;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_MATRIX_SIZE = REG_IDX_W'(0);

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	typedef struct packed {
		logic first_row;
		logic last_row;
		logic first_col;
		logic last_col;
		logic on_main;
		logic on_anti;
	} pos_t;

	typedef struct packed {
		logic [ELEM_W-1:0] element;
		logic [IDX_W-1:0]  col;
		pos_t              pos;
	} entry_t;

endpackage

// ===== src/msq_if.sv =====
// ---------------------------------------------------------------------------
// msq_if
// Valid/ready channels for matrix elements and check results.
// ---------------------------------------------------------------------------
interface msq_elem_if;
	logic                                valid;
	logic                                ready;
	logic signed [msq_pkg::ELEM_W-1:0]   element;

	modport source (output valid, output element, input ready);
	modport sink (input valid, input element, output ready);
endinterface

interface msq_result_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 is_magic;
	logic signed [msq_pkg::OUT_SUM_W-1:0] magic_sum;

	modport source (output valid, output is_magic, output magic_sum, input ready);
	modport sink (input valid, input is_magic, input magic_sum, output ready);
endinterface

// ===== src/msq_front.sv =====
// ---------------------------------------------------------------------------
// msq_front
// Holds the side length, tracks the position of each accepted element and
// tags it with its row, column and diagonal roles.
// ---------------------------------------------------------------------------
module msq_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr,
	input  logic [msq_pkg::SIZE_W-1:0]        cfg_data,
	output logic [msq_pkg::SIZE_W-1:0]        matrix_size,
	msq_elem_if.sink                          elements,
	input  logic                              q_full,
	output logic                              push,
	output msq_pkg::entry_t                   push_entry
);

	logic [msq_pkg::SIZE_W-1:0] size_q;
	logic [msq_pkg::IDX_W-1:0]  row_q;
	logic [msq_pkg::IDX_W-1:0]  col_q;
	logic [msq_pkg::SIDE_W-1:0] side;
	logic [msq_pkg::IDX_W-1:0]  last;
	msq_pkg::pos_t              pos;

	always_comb begin
		priority if (size_q == '0) begin
			side = msq_pkg::SIDE_W'(1);
		end else if (msq_pkg::CMP_W'(size_q) > msq_pkg::CMP_W'(msq_pkg::MAX_SIZE)) begin
			side = msq_pkg::SIDE_W'(msq_pkg::MAX_SIZE);
		end else begin
			side = msq_pkg::SIDE_W'(size_q);
		end
	end

	assign last = msq_pkg::IDX_W'(side - msq_pkg::SIDE_W'(1));

	always_comb begin
		pos.first_row = (row_q == '0);
		pos.last_row  = (row_q == last);
		pos.first_col = (col_q == '0);
		pos.last_col  = (col_q == last);
		pos.on_main   = (row_q == col_q);
		pos.on_anti   = ({1'b0, row_q} + {1'b0, col_q}) == {1'b0, last};
	end

	assign elements.ready     = !q_full;
	assign push               = elements.valid && elements.ready;
	assign push_entry.element = elements.element;
	assign push_entry.col     = col_q;
	assign push_entry.pos     = pos;
	assign matrix_size        = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= msq_pkg::SIZE_RESET;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_wr) begin
			size_q <= cfg_data;
			row_q  <= '0;
			col_q  <= '0;
		end else if (push) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + msq_pkg::IDX_W'(1);
			end else begin
				col_q <= col_q + msq_pkg::IDX_W'(1);
			end
		end
	end

endmodule

// ===== src/msq_queue.sv =====
// ---------------------------------------------------------------------------
// msq_queue
// Two-entry queue of tagged elements between front and back.
// ---------------------------------------------------------------------------
module msq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  msq_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output msq_pkg::entry_t head
);

	msq_pkg::entry_t             mem_q [msq_pkg::Q_DEPTH];
	logic [msq_pkg::QPTR_W-1:0]  wr_q;
	logic [msq_pkg::QPTR_W-1:0]  rd_q;
	logic [msq_pkg::QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == msq_pkg::QCNT_W'(msq_pkg::Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + msq_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + msq_pkg::QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + msq_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - msq_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/msq_back.sv =====
// ---------------------------------------------------------------------------
// msq_back
// Accumulates row, column and diagonal sums, checks each completed line
// against the first row's sum and registers the result of each matrix.
// ---------------------------------------------------------------------------
module msq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  msq_pkg::entry_t head,
	output logic            pop,
	msq_result_if.source    results
);

	logic signed [msq_pkg::SUM_W-1:0] row_q;
	logic signed [msq_pkg::SUM_W-1:0] ref_q;
	logic signed [msq_pkg::SUM_W-1:0] main_q;
	logic signed [msq_pkg::SUM_W-1:0] anti_q;
	logic signed [msq_pkg::SUM_W-1:0] col_sum_q [msq_pkg::MAX_SIZE];
	logic                             mismatch_q;

	logic                             valid_q;
	logic                             is_magic_q;
	logic signed [msq_pkg::OUT_SUM_W-1:0] magic_sum_q;

	logic signed [msq_pkg::SUM_W-1:0] v;
	logic signed [msq_pkg::SUM_W-1:0] v_main;
	logic signed [msq_pkg::SUM_W-1:0] v_anti;
	logic signed [msq_pkg::SUM_W-1:0] row_new;
	logic signed [msq_pkg::SUM_W-1:0] col_new;
	logic signed [msq_pkg::SUM_W-1:0] main_new;
	logic signed [msq_pkg::SUM_W-1:0] anti_new;
	logic signed [msq_pkg::SUM_W-1:0] ref_new;
	logic                             first_elem;
	logic                             final_elem;
	logic                             bad;

	assign v = {{(msq_pkg::SUM_W - msq_pkg::ELEM_W){head.element[msq_pkg::ELEM_W-1]}},
		head.element};
	assign v_main = head.pos.on_main ? v : '0;
	assign v_anti = head.pos.on_anti ? v : '0;

	assign first_elem = head.pos.first_row && head.pos.first_col;
	assign final_elem = head.pos.last_row && head.pos.last_col;

	assign row_new  = head.pos.first_col ? v : row_q + v;
	assign col_new  = head.pos.first_row ? v : col_sum_q[head.col] + v;
	assign main_new = first_elem ? v_main : main_q + v_main;
	assign anti_new = first_elem ? v_anti : anti_q + v_anti;
	assign ref_new  = (head.pos.first_row && head.pos.last_col) ? row_new : ref_q;

	always_comb begin
		bad = first_elem ? 1'b0 : mismatch_q;
		if (head.pos.last_col && !head.pos.first_row && row_new != ref_q) begin
			bad = 1'b1;
		end
		if (head.pos.last_row && col_new != ref_new) begin
			bad = 1'b1;
		end
		if (final_elem && (main_new != ref_new || anti_new != ref_new)) begin
			bad = 1'b1;
		end
	end

	assign pop = q_valid && (!final_elem || !valid_q || results.ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			row_q              <= row_new;
			ref_q              <= ref_new;
			main_q             <= main_new;
			anti_q             <= anti_new;
			mismatch_q         <= bad;
			col_sum_q[head.col] <= col_new;
			if (final_elem) begin
				is_magic_q  <= !bad;
				magic_sum_q <= ref_new[msq_pkg::OUT_SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && final_elem) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign results.valid     = valid_q;
	assign results.is_magic  = is_magic_q;
	assign results.magic_sum = magic_sum_q;

endmodule

// ===== src/magic_square_check.sv =====
// ---------------------------------------------------------------------------
// magic_square_check
// Streams an n by n signed matrix in row-major order and reports whether it
// is a magic square, together with the first row's sum.
// ---------------------------------------------------------------------------
// Elements are accepted one per cycle while the queue has room. Each element
// is tagged with its position by the front end, passes a two-entry queue and
// is folded into the row, column and diagonal sums by the back end; that
// accumulate step sets the rate of one element per clock. The result of a
// matrix is registered when its last element leaves the queue and waits in
// an output register while the next matrix streams in. Writing matrix_size
// (register 0, byte address 0) restarts the scan; sizes of 0 act as 1 and
// sizes above 16 act as 16. No clearing pass is needed after reset.
module magic_square_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msq_pkg::PADDR_W-1:0]   paddr,
	input  logic [msq_pkg::PDATA_W-1:0]   pwdata,
	output logic [msq_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	msq_elem_if.sink                      elements,
	msq_result_if.source                  results
);

	logic                              reg_hit;
	logic                              cfg_wr;
	logic [msq_pkg::SIZE_W-1:0]        matrix_size;
	logic                              q_full;
	logic                              q_valid;
	logic                              push;
	logic                              pop;
	msq_pkg::entry_t                   push_entry;
	msq_pkg::entry_t                   head;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[msq_pkg::PADDR_W-1:2] == msq_pkg::REG_MATRIX_SIZE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? msq_pkg::PDATA_W'(matrix_size) : '0;

	msq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.cfg_data    (pwdata[msq_pkg::SIZE_W-1:0]),
		.matrix_size (matrix_size),
		.elements    (elements),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	msq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.valid      (q_valid),
		.head       (head)
	);

	msq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

`ifndef NO_ASSERTIONS
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(pop && head.pos.last_row && head.pos.last_col))
		else $error("result raised without a completing element");

	a_pop_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.pos.last_row && head.pos.last_col |-> (!results.valid || results.ready))
		else $error("element retired while result register blocked");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue popped while empty");
`endif

endmodule
